// ===== src/cwpw_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the clipped window pixel writer.
package cwpw_pkg;

   localparam int COORD_BITS     = 16;
   localparam int FIELD_BITS     = 16;
   localparam int COLOR_BITS     = 32;
   localparam int CMD_BITS       = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [COORD_BITS-1:0]     coord_type;
   typedef logic [FIELD_BITS-1:0]     field_type;
   typedef logic [COLOR_BITS-1:0]     color_type;
   typedef logic [CMD_BITS-1:0]       cmd_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   localparam coord_type RESET_SIZE = COORD_BITS'(100);

   localparam cmd_type CMD_POINT  = 2'd0;
   localparam cmd_type CMD_WINDOW = 2'd1;
   localparam cmd_type CMD_PIXEL  = 2'd2;

   localparam csr_index_type REG_LOGICAL_WIDTH  = 3'd0;
   localparam csr_index_type REG_VIRTUAL_HEIGHT = 3'd1;
   localparam csr_index_type REG_OFFSET_X       = 3'd2;
   localparam csr_index_type REG_OFFSET_Y       = 3'd3;
   localparam csr_index_type REG_PANEL_WIDTH    = 3'd4;
   localparam csr_index_type REG_PANEL_HEIGHT   = 3'd5;

   typedef struct packed {
      coord_type logical_width;
      coord_type virtual_height;
      coord_type offset_x;
      coord_type offset_y;
      coord_type panel_width;
      coord_type panel_height;
   } cfg_type;

   typedef struct packed {
      cmd_type   command;
      field_type x_a;
      field_type y_a;
      field_type x_b;
      field_type y_b;
      color_type color;
   } req_type;

   typedef struct packed {
      logic      status;
      logic      pixel_valid;
      field_type pixel_x;
      field_type pixel_y;
      color_type pixel_color;
   } rsp_type;

endpackage

// ===== src/cwpw_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: command, coordinates and color with valid/ready.
interface cwpw_req_if import cwpw_pkg::*; ();
   logic      valid;
   logic      ready;
   cmd_type   command;
   field_type x_a;
   field_type y_a;
   field_type x_b;
   field_type y_b;
   color_type color;

   modport source (output valid, output command, output x_a, output y_a, output x_b,
                   output y_b, output color, input ready);
   modport sink (input valid, input command, input x_a, input y_a, input x_b,
                 input y_b, input color, output ready);
endinterface

// ===== src/cwpw_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: status and issued pixel with valid/ready.
interface cwpw_rsp_if import cwpw_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      status;
   logic      pixel_valid;
   field_type pixel_x;
   field_type pixel_y;
   color_type pixel_color;

   modport source (output valid, output status, output pixel_valid, output pixel_x,
                   output pixel_y, output pixel_color, input ready);
   modport sink (input valid, input status, input pixel_valid, input pixel_x,
                 input pixel_y, input pixel_color, output ready);
endinterface

// ===== src/cwpw_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers: virtual area, offsets and panel size.
module cwpw_csr import cwpw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_write_data,
   output cfg_type       cfg
);

   cfg_type   cfg_ff;
   coord_type wdata;

   assign wdata = csr_write_data[COORD_BITS-1:0];
   assign cfg   = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.logical_width  <= RESET_SIZE;
         cfg_ff.virtual_height <= RESET_SIZE;
         cfg_ff.offset_x       <= '0;
         cfg_ff.offset_y       <= '0;
         cfg_ff.panel_width    <= RESET_SIZE;
         cfg_ff.panel_height   <= RESET_SIZE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LOGICAL_WIDTH:  cfg_ff.logical_width  <= wdata;
            REG_VIRTUAL_HEIGHT: cfg_ff.virtual_height <= wdata;
            REG_OFFSET_X:       cfg_ff.offset_x       <= wdata;
            REG_OFFSET_Y:       cfg_ff.offset_y       <= wdata;
            REG_PANEL_WIDTH:    cfg_ff.panel_width    <= wdata;
            REG_PANEL_HEIGHT:   cfg_ff.panel_height   <= wdata;
            default: ;
         endcase
      end
   end

endmodule

// ===== src/cwpw_engine.sv =====
`timescale 1ns / 1ps
// Clipping, window load and raster cursor with its state registers.
module cwpw_engine import cwpw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic      window_ok_ff, window_ok_in;
   coord_type cursor_x_ff, cursor_x_in;
   coord_type cursor_y_ff, cursor_y_in;
   coord_type window_left_ff, window_left_in;
   coord_type window_right_ff, window_right_in;

   coord_type xa, ya, xb, yb;
   coord_type px1, py1, px2, py2;
   coord_type next_x;
   logic      point_ok, window_fit;

   assign xa = req.x_a[COORD_BITS-1:0];
   assign ya = req.y_a[COORD_BITS-1:0];
   assign xb = req.x_b[COORD_BITS-1:0];
   assign yb = req.y_b[COORD_BITS-1:0];

   assign px1    = xa + cfg.offset_x;
   assign py1    = ya + cfg.offset_y;
   assign px2    = xb + cfg.offset_x;
   assign py2    = yb + cfg.offset_y;
   assign next_x = cursor_x_ff + COORD_BITS'(1);

   assign point_ok = (xa < cfg.logical_width) && (ya < cfg.virtual_height) &&
                     (px1 < cfg.panel_width) && (py1 < cfg.panel_height);

   assign window_fit = point_ok && (xa <= xb) && (ya <= yb) &&
                       (xb < cfg.logical_width) && (yb < cfg.virtual_height) &&
                       (px2 < cfg.panel_width) && (py2 < cfg.panel_height);

   always_comb begin
      rsp             = '0;
      rsp.status      = 1'b1;
      window_ok_in    = window_ok_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      window_left_in  = window_left_ff;
      window_right_in = window_right_ff;
      unique case (req.command)
         CMD_POINT: begin
            if (point_ok) begin
               rsp.status      = 1'b0;
               rsp.pixel_valid = 1'b1;
               rsp.pixel_x     = FIELD_BITS'(px1);
               rsp.pixel_y     = FIELD_BITS'(py1);
               rsp.pixel_color = req.color;
            end
         end
         CMD_WINDOW: begin
            window_ok_in = window_fit;
            if (window_fit) begin
               rsp.status      = 1'b0;
               window_left_in  = px1;
               window_right_in = px2;
               cursor_x_in     = px1;
               cursor_y_in     = py1;
            end
         end
         CMD_PIXEL: begin
            if (window_ok_ff) begin
               rsp.status      = 1'b0;
               rsp.pixel_valid = 1'b1;
               rsp.pixel_x     = FIELD_BITS'(cursor_x_ff);
               rsp.pixel_y     = FIELD_BITS'(cursor_y_ff);
               rsp.pixel_color = req.color;
               if (next_x > window_right_ff) begin
                  cursor_x_in = window_left_ff;
                  cursor_y_in = cursor_y_ff + COORD_BITS'(1);
               end else begin
                  cursor_x_in = next_x;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ok_ff    <= 1'b0;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         window_left_ff  <= '0;
         window_right_ff <= '0;
      end else if (advance) begin
         window_ok_ff    <= window_ok_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         window_left_ff  <= window_left_in;
         window_right_ff <= window_right_in;
      end
   end

endmodule

// ===== src/clipped_window_pixel_writer_core.sv =====
`timescale 1ns / 1ps
// Clipped window pixel writer: point writes, window set and streamed pixel data.
//
// Requests enter on req_chan (valid/ready): command 0 writes one point,
// command 1 sets a drawing window, command 2 writes one pixel at the raster
// cursor, which then steps along x and wraps to the window's left column on
// the next row. Each request yields exactly one response on rsp_chan with a
// status bit and, when a pixel goes to the panel, its panel coordinate and
// color. Point and window coordinates are clipped against the virtual area,
// shifted by the offsets and clipped against the panel.
// The csr_ port writes one of the six size and offset registers per cycle;
// write them only while no request is in flight.
// A request accepted into the input register passes through the clip and
// cursor logic into the response register, which drives response valid.
// Throughput is one request per cycle while responses are taken. A stalled
// response holds; the input register still takes one more request and then
// ready drops until the response is taken.
// Reset clears the window flag, cursor and window registers, empties both
// stages and loads the default sizes of 100 and zero offsets.
module clipped_window_pixel_writer_core import cwpw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   cwpw_req_if.sink      req_chan,
   cwpw_rsp_if.source    rsp_chan,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_write_data
);

   cfg_type cfg;
   req_type in_ff;
   logic    in_valid_ff;
   rsp_type out_ff, result;
   logic    out_valid_ff;
   logic    advance, req_ready, req_fire;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_chan.valid && req_ready;

   assign req_chan.ready = req_ready;

   cwpw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cwpw_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_ff),
      .cfg     (cfg),
      .rsp     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff.command <= req_chan.command;
         in_ff.x_a     <= req_chan.x_a;
         in_ff.y_a     <= req_chan.y_a;
         in_ff.x_b     <= req_chan.x_b;
         in_ff.y_b     <= req_chan.y_b;
         in_ff.color   <= req_chan.color;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.pixel_valid = out_ff.pixel_valid;
   assign rsp_chan.pixel_x     = out_ff.pixel_x;
   assign rsp_chan.pixel_y     = out_ff.pixel_y;
   assign rsp_chan.pixel_color = out_ff.pixel_color;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while both stages are full");

   a_fire_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> in_valid_ff)
      else $error("accepted request lost from input stage");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("advanced request did not produce a response");

   a_pixel_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.pixel_valid |-> !rsp_chan.status)
      else $error("pixel issued with rejected status");

   a_reject_is_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status |-> !rsp_chan.pixel_valid &&
         rsp_chan.pixel_x == '0 && rsp_chan.pixel_y == '0 && rsp_chan.pixel_color == '0)
      else $error("rejected response carries pixel data");

endmodule
